@@ hw/rtl/triangle_tangent_generator_assert.svh @@
// assertion macros for the triangle tangent generator
// used by the top level only, no other dependencies
`ifndef TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH
`define TRIANGLE_TANGENT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define TTG_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTG_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ttg_pkg.sv @@
// shared types, constants and helpers of the triangle tangent generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ttg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SCALE_W = 20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd100000;
  localparam logic [1:0] CORNER_LAST = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] e1x;
    logic signed [WORD_W-1:0] e1y;
    logic signed [WORD_W-1:0] e1z;
    logic signed [WORD_W-1:0] e2x;
    logic signed [WORD_W-1:0] e2y;
    logic signed [WORD_W-1:0] e2z;
    logic signed [WORD_W-1:0] du1;
    logic signed [WORD_W-1:0] dv1;
    logic signed [WORD_W-1:0] du2;
    logic signed [WORD_W-1:0] dv2;
  } job_t;

  typedef struct packed {
    logic busy;
    logic result_valid;
  } back_stat_t;

  // difference saturated to +-(2^31-1)
  function automatic logic signed [WORD_W-1:0] sat_delta(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    logic signed [WORD_W:0] r;
    r = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (r > 33'sh0_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (r < -33'sh0_7fff_ffff) begin
      return 32'sh8000_0001;
    end
    return r[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ttg_vertex_if.sv @@
// vertex item channel: valid, ready and one vertex
// depends on ttg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ttg_vertex_if
  import ttg_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 24
);
  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    vertex_index;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] pos_z;
  logic signed [WORD_W-1:0] tex_u;
  logic signed [WORD_W-1:0] tex_v;

  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  input ready);
  modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ttg_tangent_if.sv @@
// tangent item channel: valid, ready, three indices and a tangent
// depends on ttg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ttg_tangent_if
  import ttg_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 24
);
  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    first_index;
  logic [INDEX_BITS-1:0]    second_index;
  logic [INDEX_BITS-1:0]    third_index;
  logic signed [WORD_W-1:0] tangent_x;
  logic signed [WORD_W-1:0] tangent_y;
  logic signed [WORD_W-1:0] tangent_z;

  modport source (output valid, first_index, second_index, third_index,
                  tangent_x, tangent_y, tangent_z, input ready);
  modport sink (input valid, first_index, second_index, third_index,
                tangent_x, tangent_y, tangent_z, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ttg_front.sv @@
// front end: collects three vertices, forms saturated edges and uv deltas
// depends on ttg_pkg and ttg_vertex_if
`timescale 1ns / 1ps
`default_nettype none

module ttg_front
  import ttg_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ttg_vertex_if.sink                       vertex_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output job_t                             job_o,
  output logic [2:0][INDEX_BITS-1:0]       idx_o
);

  logic [1:0]               cnt_q, cnt_d;
  logic signed [WORD_W-1:0] hx_q [2];
  logic signed [WORD_W-1:0] hy_q [2];
  logic signed [WORD_W-1:0] hz_q [2];
  logic signed [WORD_W-1:0] hu_q [2];
  logic signed [WORD_W-1:0] hv_q [2];
  logic [INDEX_BITS-1:0]    hi_q [2];
  logic                     accept;

  assign vertex_i.ready = (cnt_q != CORNER_LAST) || !q_full_i;
  assign accept = vertex_i.valid && vertex_i.ready;
  assign push_o = accept && (cnt_q == CORNER_LAST);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = (cnt_q == CORNER_LAST) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q != CORNER_LAST)) begin
      hx_q[cnt_q[0]] <= vertex_i.pos_x;
      hy_q[cnt_q[0]] <= vertex_i.pos_y;
      hz_q[cnt_q[0]] <= vertex_i.pos_z;
      hu_q[cnt_q[0]] <= vertex_i.tex_u;
      hv_q[cnt_q[0]] <= vertex_i.tex_v;
      hi_q[cnt_q[0]] <= vertex_i.vertex_index;
    end
  end

  always_comb begin
    job_o.e1x = sat_delta(hx_q[1], hx_q[0]);
    job_o.e1y = sat_delta(hy_q[1], hy_q[0]);
    job_o.e1z = sat_delta(hz_q[1], hz_q[0]);
    job_o.e2x = sat_delta(vertex_i.pos_x, hx_q[0]);
    job_o.e2y = sat_delta(vertex_i.pos_y, hy_q[0]);
    job_o.e2z = sat_delta(vertex_i.pos_z, hz_q[0]);
    job_o.du1 = sat_delta(hu_q[1], hu_q[0]);
    job_o.dv1 = sat_delta(hv_q[1], hv_q[0]);
    job_o.du2 = sat_delta(vertex_i.tex_u, hu_q[0]);
    job_o.dv2 = sat_delta(vertex_i.tex_v, hv_q[0]);
    idx_o[0]  = hi_q[0];
    idx_o[1]  = hi_q[1];
    idx_o[2]  = vertex_i.vertex_index;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ttg_fifo.sv @@
// two-entry queue between front and back end
// depends on ttg_pkg only for the common import style
`timescale 1ns / 1ps
`default_nettype none

module ttg_fifo
  import ttg_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   empty_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ttg_back.sv @@
// back end: determinant and numerators on one shared multiplier, then per axis
// a bit-serial divider or shift-add scaler; depends on ttg_pkg, ttg_tangent_if
`timescale 1ns / 1ps
`default_nettype none

module ttg_back
  import ttg_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned INDEX_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  output logic                             job_pop_o,
  input  wire job_t                        job_i,
  input  wire logic [2:0][INDEX_BITS-1:0]  idx_i,
  input  wire logic [SCALE_W-1:0]          scale_i,
  ttg_tangent_if.source                    tangent_o,
  output back_stat_t                       stat_o
);

  localparam int unsigned DW = 64 + FRAC_BITS;
  localparam int unsigned AW = 64 + SCALE_W;
  localparam int unsigned WW = (DW > AW) ? DW : AW;
  localparam int unsigned CW = $clog2(WW + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PROD = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_ITER = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_e;

  back_state_e              state_q;
  job_t                     job_q;
  logic [2:0][INDEX_BITS-1:0] idx_q;
  logic [3:0]               pcnt_q;
  logic signed [63:0]       prod_q, tmp_q, det_q;
  logic signed [63:0]       n_q [3];
  logic [1:0]               ax_q;
  logic                     use_div_q, neg_q, nz_q;
  logic [63:0]              rem_q;
  logic [DW-1:0]            dvd_q, quo_q;
  logic [AW-1:0]            acc_q, mc_q;
  logic [SCALE_W-1:0]       sc_q;
  logic [CW-1:0]            icnt_q;
  logic signed [WORD_W-1:0] tan_q [2];
  logic signed [WORD_W-1:0] ma, mb;
  logic signed [63:0]       diff;
  logic signed [63:0]       n_cur;
  logic [63:0]              mag_in;
  logic [64:0]              r2, dd;
  logic                     ge;
  logic [WW-1:0]            mag, lim, res;
  logic [WORD_W-1:0]        res32, tan_cur;
  logic                     nz_all;

  assign job_pop_o          = (state_q == ST_IDLE) && job_valid_i;
  assign stat_o.busy        = state_q != ST_IDLE;
  assign stat_o.result_valid = state_q == ST_OUT;
  assign tangent_o.valid    = state_q == ST_OUT;

  always_comb begin
    case (pcnt_q)
      4'd0:    begin ma = job_q.du1; mb = job_q.dv2; end
      4'd1:    begin ma = job_q.du2; mb = job_q.dv1; end
      4'd2:    begin ma = job_q.dv2; mb = job_q.e1x; end
      4'd3:    begin ma = job_q.dv1; mb = job_q.e2x; end
      4'd4:    begin ma = job_q.dv2; mb = job_q.e1y; end
      4'd5:    begin ma = job_q.dv1; mb = job_q.e2y; end
      4'd6:    begin ma = job_q.dv2; mb = job_q.e1z; end
      default: begin ma = job_q.dv1; mb = job_q.e2z; end
    endcase
    diff   = tmp_q - prod_q;
    n_cur  = n_q[ax_q];
    mag_in = n_cur[63] ? 64'(-n_cur) : 64'(n_cur);
    r2     = {rem_q, dvd_q[DW-1]};
    dd     = {1'b0, det_q};
    ge     = r2 >= dd;
    mag    = use_div_q ? WW'(quo_q) : WW'(acc_q >> FRAC_BITS);
    lim    = neg_q ? WW'(33'h0_8000_0000) : WW'(33'h0_7fff_ffff);
    res    = (mag > lim) ? lim : mag;
    res32  = res[WORD_W-1:0];
    tan_cur = neg_q ? WORD_W'(-res32) : res32;
    nz_all = nz_q || (res32 != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pcnt_q  <= 4'd0;
      ax_q    <= 2'd0;
      icnt_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_PROD;
            pcnt_q  <= 4'd0;
          end
        end
        ST_PROD: begin
          pcnt_q <= pcnt_q + 4'd1;
          if (pcnt_q == 4'd8) begin
            state_q <= ST_LOAD;
            ax_q    <= 2'd0;
          end
        end
        ST_LOAD: begin
          state_q <= ST_ITER;
          icnt_q  <= use_div_q ? CW'(DW) : CW'(SCALE_W);
        end
        ST_ITER: begin
          icnt_q <= icnt_q - CW'(1);
          if (icnt_q == CW'(1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (ax_q == 2'd2) begin
            state_q <= ST_OUT;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (tangent_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
          idx_q <= idx_i;
          nz_q  <= 1'b0;
        end
      end
      ST_PROD: begin
        if (pcnt_q != 4'd8) begin
          prod_q <= 64'(ma) * 64'(mb);
        end
        case (pcnt_q)
          4'd1, 4'd3, 4'd5, 4'd7: tmp_q <= prod_q;
          4'd2: det_q  <= diff;
          4'd4: n_q[0] <= diff;
          4'd6: n_q[1] <= diff;
          4'd8: begin
            n_q[2]    <= diff;
            use_div_q <= det_q > 64'sd0;
          end
          default: tmp_q <= tmp_q;
        endcase
      end
      ST_LOAD: begin
        neg_q <= n_cur[63];
        rem_q <= '0;
        dvd_q <= {mag_in, {FRAC_BITS{1'b0}}};
        quo_q <= '0;
        acc_q <= '0;
        mc_q  <= AW'(mag_in);
        sc_q  <= scale_i;
      end
      ST_ITER: begin
        if (use_div_q) begin
          rem_q <= ge ? 64'(r2 - dd) : r2[63:0];
          dvd_q <= dvd_q << 1;
          quo_q <= {quo_q[DW-2:0], ge};
        end else begin
          if (sc_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mc_q <= mc_q << 1;
          sc_q <= sc_q >> 1;
        end
      end
      ST_FIN: begin
        nz_q <= nz_all;
        if (ax_q == 2'd2) begin
          tangent_o.first_index  <= idx_q[0];
          tangent_o.second_index <= idx_q[1];
          tangent_o.third_index  <= idx_q[2];
          if (nz_all) begin
            tangent_o.tangent_x <= tan_q[0];
            tangent_o.tangent_y <= tan_q[1];
            tangent_o.tangent_z <= tan_cur;
          end else begin
            tangent_o.tangent_x <= WORD_W'(1) << FRAC_BITS;
            tangent_o.tangent_y <= '0;
            tangent_o.tangent_z <= '0;
          end
        end else begin
          tan_q[ax_q[0]] <= tan_cur;
        end
      end
      default: nz_q <= nz_q;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/triangle_tangent_generator.sv @@
// triangle tangent generator, top level: front end, queue, back end, scale register
// the result path runs through the serial divider when the uv determinant is positive and
// through the serial scaler otherwise
// throughput: one vertex per cycle into the front while the two-entry queue has room; the
// back end takes a new triangle only after the previous result has been accepted
// reset: asynchronous active low, clears counters, queue and state, scale to 100000
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_tangent_generator_assert.svh"

module triangle_tangent_generator
  import ttg_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned INDEX_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [SCALE_W-1:0] cfg_wdata_i,
  ttg_vertex_if.sink              vertex_i,
  ttg_tangent_if.source           tangent_o
);

  localparam int unsigned QW = 3 * INDEX_BITS + $bits(job_t);

  logic [SCALE_W-1:0]         scale_q;
  logic                       q_push, q_pop, q_full, q_empty;
  job_t                       f_job, b_job;
  logic [2:0][INDEX_BITS-1:0] f_idx, b_idx;
  logic [QW-1:0]              q_out;
  back_stat_t                 bstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  ttg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vertex_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (f_job),
    .idx_o    (f_idx)
  );

  ttg_fifo #(.DATA_W(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_idx, f_job}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign {b_idx, b_job} = q_out;

  ttg_back #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_pop_o   (q_pop),
    .job_i       (b_job),
    .idx_i       (b_idx),
    .scale_i     (scale_q),
    .tangent_o   (tangent_o),
    .stat_o      (bstat)
  );

  `TTG_AST_IMP(a_no_push_when_full, clk_i, rst_ni, q_full, !q_push, "push into full queue")
  `TTG_AST_NXT(a_push_fills, clk_i, rst_ni, q_push && !q_pop, !q_empty, "pushed item lost")
  `TTG_AST_NXT(a_pop_starts_back, clk_i, rst_ni, q_pop, bstat.busy && !bstat.result_valid,
               "popped item not taken up")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench for the triangle tangent generator: directed vertex table, then random
// triangles checked against an in-bench tangent predictor
// depends on ttg_pkg, ttg_vertex_if, ttg_tangent_if and the top level rtl
`timescale 1ns / 1ps

module testbench;
  import ttg_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned IDXW = 24;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic signed [31:0] px, py, pz, tu, tv;
  } vertex_t;

  typedef struct packed {
    logic [IDXW-1:0] i0, i1, i2;
    logic signed [31:0] tx, ty, tz;
  } tangent_t;

  typedef struct {
    vertex_t vtx;
    bit known;
    tangent_t res;
  } row_t;

  logic clk_i, rst_ni, cfg_we_i;
  logic [SCALE_W-1:0] cfg_wdata_i;

  ttg_vertex_if #(.INDEX_BITS(IDXW)) vtx_bus ();
  ttg_tangent_if #(.INDEX_BITS(IDXW)) tan_bus ();

  triangle_tangent_generator #(.FRAC_BITS(FRAC), .INDEX_BITS(IDXW)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .vertex_i(vtx_bus.sink), .tangent_o(tan_bus.source)
  );

  // predictor state
  logic [SCALE_W-1:0] scale_q;
  int unsigned corners;
  vertex_t held [2];
  tangent_t tangent_q [$];
  row_t rows [$];
  int errors;
  int cycles;
  bit sink_busy;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  task automatic add_row(input vertex_t v, input bit known, input tangent_t res);
    row_t r;
    r.vtx = v;
    r.known = known;
    r.res = res;
    rows.insert(rows.size(), r);
  endtask

  function automatic logic signed [63:0] sat_diff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] r;
    r = 64'(a) - 64'(b);
    if (r > 64'sh7fffffff) return 64'sh7fffffff;
    if (r < -64'sh7fffffff) return -64'sh7fffffff;
    return r;
  endfunction

  function automatic logic signed [31:0] axis_value(input logic signed [63:0] n,
                                                   input logic signed [63:0] d,
                                                   input bit by_det, inout bit all_zero);
    logic [127:0] mag, q, lim;
    logic [63:0] m;
    m = n < 0 ? 64'(-n) : 64'(n);
    lim = n < 0 ? 128'h80000000 : 128'h7fffffff;
    if (by_det) q = ({64'd0, m} << FRAC) / {64'd0, d};
    else q = ({64'd0, m} * scale_q) >> FRAC;
    mag = q > lim ? lim : q;
    if (mag != 0) all_zero = 1'b0;
    return n < 0 ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic tangent_t triangle_tangent(input vertex_t a, input vertex_t b,
                                                input vertex_t c);
    tangent_t t;
    logic signed [63:0] e1 [3], e2 [3], du1, dv1, du2, dv2, det, n;
    logic signed [31:0] r [3];
    bit by_det, all_zero;
    e1[0] = sat_diff(b.px, a.px); e1[1] = sat_diff(b.py, a.py); e1[2] = sat_diff(b.pz, a.pz);
    e2[0] = sat_diff(c.px, a.px); e2[1] = sat_diff(c.py, a.py); e2[2] = sat_diff(c.pz, a.pz);
    du1 = sat_diff(b.tu, a.tu); dv1 = sat_diff(b.tv, a.tv);
    du2 = sat_diff(c.tu, a.tu); dv2 = sat_diff(c.tv, a.tv);
    det = du1 * dv2 - du2 * dv1;
    by_det = det > 0;
    all_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      n = dv2 * e1[k] - dv1 * e2[k];
      r[k] = axis_value(n, det, by_det, all_zero);
    end
    if (all_zero) begin
      r[0] = 32'sd1 <<< FRAC; r[1] = 0; r[2] = 0;
    end
    t.i0 = a.idx; t.i1 = b.idx; t.i2 = c.idx;
    t.tx = r[0]; t.ty = r[1]; t.tz = r[2];
    return t;
  endfunction

  function automatic int idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    return n;
  endfunction

  task automatic send_vertex(input vertex_t v, input bit known, input tangent_t res);
    int n;
    vtx_bus.valid <= 1'b1;
    {vtx_bus.vertex_index, vtx_bus.pos_x, vtx_bus.pos_y, vtx_bus.pos_z,
     vtx_bus.tex_u, vtx_bus.tex_v} <= v;
    do @(posedge clk_i); while (!vtx_bus.ready);
    if (corners < 2) begin
      held[corners] = v;
      corners++;
    end else begin
      corners = 0;
      tangent_q.insert(tangent_q.size(), known ? res : triangle_tangent(held[0], held[1], v));
    end
    @(negedge clk_i);
    n = idle_gap();
    if (n != 0) begin
      vtx_bus.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] s);
    vtx_bus.valid <= 1'b0;
    while (tangent_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scale_q = s;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 8)) <<< 16;
      3: return $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.idx = $urandom();
    v.px = rand_word(); v.py = rand_word(); v.pz = rand_word();
    v.tu = rand_word(); v.tv = rand_word();
    return v;
  endfunction

  // result side: random stalls unless sink_busy holds ready high, checks against the oldest expected item
  initial begin
    tangent_t got, exp;
    int hold;
    tan_bus.ready = 1'b0;
    errors = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_busy) begin
        tan_bus.ready <= 1'b1;
      end else if (hold != 0) begin
        tan_bus.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 39) == 0) begin
        tan_bus.ready <= 1'b0;
        hold = $urandom_range(5, 60);
      end else begin
        tan_bus.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
      @(posedge clk_i);
      if (tan_bus.valid && tan_bus.ready) begin
        got = {tan_bus.first_index, tan_bus.second_index, tan_bus.third_index,
               tan_bus.tangent_x, tan_bus.tangent_y, tan_bus.tangent_z};
        if (tangent_q.size() == 0) begin
          report("unexpected item", 64'(got.i0), 64'd0);
        end else begin
          exp = tangent_q.pop_front();
          if (got.i0 !== exp.i0) report("first_index", 64'(got.i0), 64'(exp.i0));
          if (got.i1 !== exp.i1) report("second_index", 64'(got.i1), 64'(exp.i1));
          if (got.i2 !== exp.i2) report("third_index", 64'(got.i2), 64'(exp.i2));
          if (got.tx !== exp.tx) report("tangent_x", 64'(got.tx), 64'(exp.tx));
          if (got.ty !== exp.ty) report("tangent_y", 64'(got.ty), 64'(exp.ty));
          if (got.tz !== exp.tz) report("tangent_z", 64'(got.tz), 64'(exp.tz));
        end
      end
    end
  end

  initial begin
    row_t r;
    tangent_t none;
    logic [SCALE_W-1:0] scales [4];
    none = '0;
    sink_busy = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    vtx_bus.valid = 1'b0;
    {vtx_bus.vertex_index, vtx_bus.pos_x, vtx_bus.pos_y, vtx_bus.pos_z,
     vtx_bus.tex_u, vtx_bus.tex_v} = '0;
    scale_q = SCALE_RESET;
    corners = 0;
    held[0] = '0; held[1] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unit triangle, uv equal to xy: tangent is exactly (1,0,0)
    add_row('{24'd0, 0, 0, 0, 0, 0}, 0, none);
    add_row('{24'd1, 32'sh10000, 0, 0, 32'sh10000, 0}, 0, none);
    add_row('{24'd2, 0, 32'sh10000, 0, 0, 32'sh10000}, 1,
            '{24'd0, 24'd1, 24'd2, 32'sh10000, 0, 0});
    // degenerate uv, zero numerator: all-zero becomes (1,0,0)
    add_row('{24'hffffff, 32'sh7fffffff, 32'sh80000000, 0, 0, 0}, 0, none);
    add_row('{24'h000000, 32'sh80000000, 32'sh7fffffff, 0, 0, 0}, 0, none);
    add_row('{24'hffffff, 32'sh12345, 32'sh54321, 32'sh7fffffff, 0, 0}, 1,
            '{24'hffffff, 24'h000000, 24'hffffff, 32'sh10000, 0, 0});
    // saturated deltas and large values, checked by the predictor
    add_row('{24'h800000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000}, 0, none);
    add_row('{24'h7fffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh80000000}, 0, none);
    add_row('{24'h555555, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff}, 0, none);
    // negative determinant uses the fallback scale
    add_row('{24'h10, 0, 0, 0, 0, 0}, 0, none);
    add_row('{24'h11, 32'sh10000, 0, 0, 0, 32'sh10000}, 0, none);
    add_row('{24'h12, 0, 32'sh10000, 0, 32'sh10000, 0}, 0, none);
    // tiny positive determinant saturates the division
    add_row('{24'h20, 0, 0, 0, 0, 0}, 0, none);
    add_row('{24'h21, 32'sh7fff0000, 0, 32'sh80000000, 1, 0}, 0, none);
    add_row('{24'h22, 0, 32'sh7fff0000, 0, 0, 1}, 0, none);
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].known, rows[i].res);

    // zero scale: fallback tangent collapses to (1,0,0)
    set_scale('0);
    for (int i = 0; i < 3; i++) begin
      r.vtx = '{24'(i + 40), 32'sh10000 * i, 32'sh30000, 32'sh7000 * i, 0, 0};
      send_vertex(r.vtx, i == 2, '{24'd40, 24'd41, 24'd42, 32'sh10000, 0, 0});
    end

    scales = '{20'hfffff, 20'd1, 20'd100000, 20'h5aa5a};
    for (int ph = 0; ph < 4; ph++) begin
      set_scale(ph == 3 ? 20'($urandom()) : scales[ph]);
      if (ph == 2) sink_busy = 1'b1;
      if (ph == 3) sink_busy = 1'b0;
      for (int t = 0; t < 54; t++) begin
        vertex_t a, b, c;
        a = rand_vertex();
        // mostly small, well-conditioned triangles, some wild ones
        if ($urandom_range(0, 3) != 0) begin
          a.px = $signed(32'($urandom_range(0, 1 << 22))) - 32'sh200000;
          a.tu = $signed(32'($urandom_range(0, 1 << 18))) - 32'sh20000;
          a.tv = $signed(32'($urandom_range(0, 1 << 18))) - 32'sh20000;
          b = a; c = a;
          b.idx = $urandom(); c.idx = $urandom();
          b.px = a.px + $signed(32'($urandom_range(0, 1 << 20)));
          b.py = a.py + $signed(32'($urandom_range(0, 1 << 20))) - 32'sh80000;
          b.pz = a.pz - $signed(32'($urandom_range(0, 1 << 20)));
          c.px = a.px - $signed(32'($urandom_range(0, 1 << 20)));
          c.py = a.py + $signed(32'($urandom_range(0, 1 << 20)));
          c.pz = a.pz + $signed(32'($urandom_range(0, 1 << 20)));
          b.tu = a.tu + $signed(32'($urandom_range(0, 1 << 17))) - 32'sh8000;
          b.tv = a.tv + $signed(32'($urandom_range(0, 1 << 17))) - 32'sh8000;
          c.tu = a.tu + $signed(32'($urandom_range(0, 1 << 17))) - 32'sh8000;
          c.tv = a.tv + $signed(32'($urandom_range(0, 1 << 17))) - 32'sh8000;
        end else begin
          b = rand_vertex(); c = rand_vertex();
        end
        send_vertex(a, 1'b0, none);
        send_vertex(b, 1'b0, none);
        send_vertex(c, 1'b0, none);
      end
    end

    vtx_bus.valid <= 1'b0;
    while (tangent_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ttg_pkg.sv
hw/rtl/ttg_vertex_if.sv
hw/rtl/ttg_tangent_if.sv
hw/rtl/ttg_front.sv
hw/rtl/ttg_fifo.sv
hw/rtl/ttg_back.sv
hw/rtl/triangle_tangent_generator.sv
verif/testbench.sv
